[design/rcrfd_pkg.sv]
package rcrfd_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned ID_W            = 6;
    localparam int unsigned VALUE_W         = 10;
    localparam int unsigned WORD_W          = ID_W + VALUE_W;
    localparam int unsigned FRAME_BYTES_DEF = 16;
    localparam int unsigned MAX_RESULTS     = 7;

    localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'h03;

endpackage

[design/rc_receiver_frame_decoder.sv]
// Receiver frame decoder. Takes one serial byte per word on the s_ side and
// hunts for the sync byte 0x03, which opens a frame of FRAME_BYTES bytes.
// Byte 1 is skipped; bytes from 2 on pair up into big-endian 16-bit words,
// at most seven per frame. Each word is written to a two-bank word RAM as
// its low byte arrives. When a frame's last byte is taken, that bank is
// queued for readout, and the m_ side then gives one result per word:
// channel number (word bits 15..10) and 10-bit position (bits 9..0), with
// tlast on the final word. Input is taken one byte per cycle while s_tready
// is high; readout runs one word per cycle under m_tready, and a frame's last
// byte reaches its first result through the queue count, RAM read and output
// register. A new frame fills the other bank while one is read out; s_tready
// drops only when both banks hold frames still waiting to be read, until the
// older bank has had its final word read. No clearing pass after reset.
module rc_receiver_frame_decoder #(
    parameter int unsigned FRAME_BYTES = rcrfd_pkg::FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] channel_id, [15:6] channel_value
    output logic        m_tlast    // last_of_frame
);

    // words decoded per frame
    localparam int unsigned WORDS_RAW = (FRAME_BYTES - 2) / 2;
    localparam int unsigned WORDS     = (WORDS_RAW > rcrfd_pkg::MAX_RESULTS) ?
                                        rcrfd_pkg::MAX_RESULTS : WORDS_RAW;
    localparam int unsigned IW        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned POS_W     = $clog2(FRAME_BYTES);
    localparam int unsigned DEPTH     = 2 << IW;

    localparam logic [POS_W-1:0] POS_FINAL = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_THREE = POS_W'(3);
    localparam logic [POS_W-1:0] WORDS_POS = POS_W'(WORDS);
    localparam logic [IW-1:0]    IDX_LAST  = IW'(WORDS - 1);

    // word RAM: {bank, word index}
    logic [rcrfd_pkg::WORD_W-1:0] word_mem [DEPTH];

    // fill side
    logic                          in_frame_reg, in_frame_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          fill_bank_reg, fill_bank_next;
    logic [rcrfd_pkg::BYTE_W-1:0]  hi_byte_reg;

    // readout side
    logic [1:0]                    queued_reg, queued_next;
    logic                          rd_bank_reg, rd_bank_next;
    logic [IW-1:0]                 rd_idx_reg, rd_idx_next;
    logic                          rdv_reg, rdv_next;
    logic                          rd_last_reg;
    logic [rcrfd_pkg::WORD_W-1:0]  mem_q_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [15:0]                   m_tdata_reg;
    logic                          m_tlast_reg;

    logic                          in_acc;
    logic                          frame_done;
    logic                          wr_en;
    logic [POS_W-1:0]              word_pos;
    logic [IW-1:0]                 wr_idx;
    logic                          out_free;
    logic                          advance;
    logic                          rd_en;
    logic                          rd_final;

    assign s_tready = (queued_reg != 2'd2);
    assign in_acc   = s_tvalid && s_tready;

    assign word_pos   = (pos_reg - POS_TWO) >> 1;
    assign wr_idx     = IW'(word_pos);
    // low byte of a decoded word: odd position from 3 up, inside the word limit
    assign wr_en      = in_acc && in_frame_reg && pos_reg[0] && (pos_reg >= POS_THREE)
                        && (word_pos < WORDS_POS);
    assign frame_done = in_acc && in_frame_reg && (pos_reg == POS_FINAL);

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = rdv_reg && out_free;
    assign rd_en    = (queued_reg != 2'd0) && (!rdv_reg || advance);
    assign rd_final = rd_en && (rd_idx_reg == IDX_LAST);

    always_comb begin
        in_frame_next  = in_frame_reg;
        pos_next       = pos_reg;
        fill_bank_next = fill_bank_reg;
        if (in_acc) begin
            if (!in_frame_reg) begin
                if (s_tdata == rcrfd_pkg::SYNC_VALUE) begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_W'(1);
                end
            end else if (frame_done) begin
                in_frame_next  = 1'b0;
                pos_next       = '0;
                fill_bank_next = !fill_bank_reg;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb begin
        queued_next = queued_reg;
        if (frame_done && !rd_final) begin
            queued_next = queued_reg + 2'd1;
        end else if (!frame_done && rd_final) begin
            queued_next = queued_reg - 2'd1;
        end
        rd_idx_next  = rd_idx_reg;
        rd_bank_next = rd_bank_reg;
        if (rd_en) begin
            if (rd_final) begin
                rd_idx_next  = '0;
                rd_bank_next = !rd_bank_reg;
            end else begin
                rd_idx_next = rd_idx_reg + IW'(1);
            end
        end
        rdv_next = rd_en || (rdv_reg && !advance);
        m_tvalid_next = advance || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            fill_bank_reg <= 1'b0;
            queued_reg    <= 2'd0;
            rd_bank_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            rdv_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            fill_bank_reg <= fill_bank_next;
            queued_reg    <= queued_next;
            rd_bank_reg   <= rd_bank_next;
            rd_idx_reg    <= rd_idx_next;
            rdv_reg       <= rdv_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_acc && in_frame_reg && !pos_reg[0]) begin
            hi_byte_reg <= s_tdata;
        end
        if (rd_en) begin
            rd_last_reg <= (rd_idx_reg == IDX_LAST);
        end
        if (advance) begin
            m_tdata_reg <= {mem_q_reg[rcrfd_pkg::VALUE_W-1:0],
                            mem_q_reg[rcrfd_pkg::WORD_W-1:rcrfd_pkg::VALUE_W]};
            m_tlast_reg <= rd_last_reg;
        end
    end

    // word RAM, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_mem[{fill_bank_reg, wr_idx}] <= {hi_byte_reg, s_tdata};
        end
        if (rd_en) begin
            mem_q_reg <= word_mem[{rd_bank_reg, rd_idx_reg}];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // at most two frames outstanding
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queued_reg != 2'd3)
        else $error("frame queue overflow");

    // a fill write never lands in the bank being read out
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && queued_reg != 2'd0) |-> (fill_bank_reg != rd_bank_reg))
        else $error("fill write into pending bank");

    // every RAM read is followed by data in the read stage
    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> rdv_reg)
        else $error("read data dropped");

    // a stalled result holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)
                                          && $stable(m_tlast_reg)))
        else $error("output changed under stall");

endmodule

[test/rc_receiver_frame_decoder_tb.sv]
`timescale 1ns / 100ps

module rc_receiver_frame_decoder_tb;

    localparam int FRAME_LEN     = rcrfd_pkg::FRAME_BYTES_DEF;
    localparam int RANDOM_BYTES  = 260;
    localparam int TAIL_CYCLES   = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int SHOW_MISMATCH = 10;

    // One decoded channel as it should leave the m_ side.
    typedef struct packed {
        logic [rcrfd_pkg::ID_W-1:0]    id;
        logic [rcrfd_pkg::VALUE_W-1:0] value;
        logic                          is_last;
    } channel_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [5:0] channel_id, [15:6] channel_value
    logic        m_tlast;           // last_of_frame

    rc_receiver_frame_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Bytes waiting to be driven, and channels waiting to come out.
    logic [7:0] byte_queue[$];
    channel_t   channel_queue[$];

    // Predictor state: sync lock, bytes held so far, frame buffer.
    bit         synced;
    int         frame_pos;
    logic [7:0] frame_buf[FRAME_LEN];

    int  fail_count;
    int  idle_cycles;
    bit  s_taken;       // s_ word accepted at the last rising edge
    int  send_gap;
    int  stall_left;
    int  phase_left;
    bit  steady;        // stretch with no idling on either side

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Predictor: one accepted rx byte; pushes channels when a frame completes.
    task automatic decode_rx_byte(input logic [7:0] rx);
        int            pairs;
        int            k;
        logic [15:0]   pair_bits;
        channel_t      chan;
        bit            taken;
        taken = 1'b1;
        if (!synced) begin
            // hunting: anything but sync is dropped
            if (rx == rcrfd_pkg::SYNC_VALUE) begin
                synced       = 1'b1;
                frame_buf[0] = rx;
                frame_pos    = 1;
            end else begin
                taken = 1'b0;
            end
        end else begin
            // sync byte inside a frame is plain data
            if (frame_pos < FRAME_LEN)
                frame_buf[frame_pos] = rx;
            frame_pos = (frame_pos + 1) & 31;
        end
        if (taken && (frame_pos == 0 || frame_pos >= FRAME_LEN)) begin
            // byte 1 skipped; big-endian pairs from byte 2, capped at seven
            pairs = (FRAME_LEN - 2) / 2;
            if (pairs < 0)
                pairs = 0;
            if (pairs > rcrfd_pkg::MAX_RESULTS)
                pairs = rcrfd_pkg::MAX_RESULTS;
            for (k = 0; k < pairs; k++) begin
                pair_bits    = {frame_buf[2 + 2 * k], frame_buf[3 + 2 * k]};
                chan.id      = pair_bits[15:10];
                chan.value   = pair_bits[9:0];
                chan.is_last = (k == pairs - 1);
                channel_queue.push_back(chan);
            end
            synced    = 1'b0;
            frame_pos = 0;
        end
    endtask

    // Sync, then len-1 bytes of random content biased toward the extremes.
    task automatic queue_frame(input int len);
        int k;
        int roll;
        byte_queue.push_back(rcrfd_pkg::SYNC_VALUE);
        for (k = 1; k < len; k++) begin
            roll = $urandom_range(0, 19);
            if (roll < 2)
                byte_queue.push_back(rcrfd_pkg::SYNC_VALUE);
            else if (roll < 4)
                byte_queue.push_back(8'h00);
            else if (roll < 6)
                byte_queue.push_back(8'hFF);
            else
                byte_queue.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Hold off until every queued byte is taken and every channel is out.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (byte_queue.size() != 0 || s_tvalid || channel_queue.size() != 0);
    endtask

    // s_ driver: new word only after the current one was taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (s_tvalid && !s_taken) begin
            // still waiting on s_tready, hold word
        end else if (send_gap > 0 || byte_queue.size() == 0) begin
            s_tvalid <= 1'b0;
            if (send_gap > 0)
                send_gap <= send_gap - 1;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= byte_queue.pop_front();
            send_gap <= steady ? 0 : pick_gap();
        end
    end

    // m_ side back-pressure, plus the steady/idle phase switch.
    always @(negedge aclk) begin
        if (phase_left == 0) begin
            phase_left <= $urandom_range(20, 120);
            steady     <= ($urandom_range(0, 3) == 0);
        end else begin
            phase_left <= phase_left - 1;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: feed the predictor, check results, watch for a hang.
    always @(posedge aclk) begin
        channel_t want;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                decode_rx_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (channel_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_MISMATCH)
                        $display("unexpected word: id %0d value %0d last %0b",
                                 m_tdata[5:0], m_tdata[15:6], m_tlast);
                end else begin
                    want = channel_queue.pop_front();
                    if (m_tdata[5:0] !== want.id || m_tdata[15:6] !== want.value ||
                        m_tlast !== want.is_last) begin
                        fail_count++;
                        if (fail_count <= SHOW_MISMATCH)
                            $display("mismatch: exp %0d %0d %0b, got %0d %0d %0b",
                                     want.id, want.value, want.is_last,
                                     m_tdata[5:0], m_tdata[15:6], m_tlast);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rc_receiver_frame_decoder regression: fail");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int fed;
        int n;
        int roll;
        bit paused;
        logic [7:0] noise;
        fed    = 0;
        paused = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // non-sync bytes while hunting are dropped
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h02);
        byte_queue.push_back(8'h83);
        // one full frame: all-ones, all-zeros, max value, max id, sync as data
        byte_queue.push_back(rcrfd_pkg::SYNC_VALUE);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'h03);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'hFC);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(rcrfd_pkg::SYNC_VALUE);
        byte_queue.push_back(rcrfd_pkg::SYNC_VALUE);
        byte_queue.push_back(8'hAA);
        byte_queue.push_back(8'h55);
        byte_queue.push_back(8'h55);
        byte_queue.push_back(8'hAA);
        wait_drained();

        // random: mostly whole frames, some cut short, some line noise
        while (fed < RANDOM_BYTES) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                queue_frame(FRAME_LEN);
                fed += FRAME_LEN;
            end else if (roll < 90) begin
                n = $urandom_range(1, FRAME_LEN - 1);
                queue_frame(n);
                fed += n;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == rcrfd_pkg::SYNC_VALUE)
                        noise = 8'h00;
                    byte_queue.push_back(noise);
                end
            end
            if (!paused && fed >= RANDOM_BYTES / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && channel_queue.size() == 0)
            $display("rc_receiver_frame_decoder regression: pass");
        else
            $display("rc_receiver_frame_decoder regression: fail");
        $finish;
    end

endmodule

[files.f]
design/rcrfd_pkg.sv
design/rc_receiver_frame_decoder.sv
test/rc_receiver_frame_decoder_tb.sv
